/* hdl/swpc_pkg.sv */
// ----------------------------------------------------------------------------
// swpc_pkg
// Shared constants and types for the sliding window peak counter.
// ----------------------------------------------------------------------------
package swpc_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 1024;
  localparam int unsigned TIME_WIDTH_DEF = 32;

  localparam int unsigned TS_W       = 32;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned DIV_W      = 11;
  localparam int unsigned OUT_W      = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [WIN_W-1:0] WIN_RESET = 16'd1000;
  localparam logic [DIV_W-1:0] DIV_RESET = 11'd1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN
  } swpc_state_e;

  typedef struct packed {
    logic push;
    logic pop;
  } swpc_ctrl_t;

endpackage

/* hdl/swpc_cell.sv */
// ----------------------------------------------------------------------------
// swpc_cell
// One slot of the timestamp chain: shifts toward the front on a pop and
// captures the new timestamp when it is the first free slot on a push.
// ----------------------------------------------------------------------------
module swpc_cell #(
  parameter int unsigned TIME_WIDTH = swpc_pkg::TIME_WIDTH_DEF,
  parameter int unsigned CNT_W      = 11,
  parameter int unsigned IDX        = 0
) (
  input  logic                   clk_i,
  input  swpc_pkg::swpc_ctrl_t   ctrl_i,
  input  logic [CNT_W-1:0]       fill_i,
  input  logic [TIME_WIDTH-1:0]  new_time_i,
  input  logic [TIME_WIDTH-1:0]  next_time_i,
  output logic [TIME_WIDTH-1:0]  time_o
);

  logic [TIME_WIDTH-1:0] time_q, time_d;

  always_comb begin
    time_d = time_q;
    if (ctrl_i.pop) begin
      time_d = next_time_i;
    end else if (ctrl_i.push && (fill_i == CNT_W'(IDX))) begin
      time_d = new_time_i;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
  end

  assign time_o = time_q;

endmodule

/* hdl/swpc_div.sv */
// ----------------------------------------------------------------------------
// swpc_div
// Restoring divider, one quotient bit per cycle, for rescaling the unit
// count after the divisor changes.
// ----------------------------------------------------------------------------
module swpc_div #(
  parameter int unsigned CNT_W = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [CNT_W-1:0]            dividend_i,
  input  logic [swpc_pkg::DIV_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [CNT_W-1:0]            quot_o,
  output logic [swpc_pkg::DIV_W-1:0]  rem_o
);

  localparam int unsigned SW = $clog2(CNT_W + 1);

  logic [SW-1:0]              step_q, step_d;
  logic                       done_q, done_d;
  logic [CNT_W-1:0]           dvd_q, dvd_d;
  logic [CNT_W-1:0]           quot_q, quot_d;
  logic [swpc_pkg::DIV_W-1:0] part_q, part_d;
  logic [swpc_pkg::DIV_W:0]   trial;
  logic [swpc_pkg::DIV_W:0]   diff;
  logic                       ge;

  always_comb begin
    trial  = {part_q, dvd_q[CNT_W-1]};
    ge     = trial >= {1'b0, divisor_i};
    diff   = trial - {1'b0, divisor_i};
    step_d = step_q;
    done_d = 1'b0;
    dvd_d  = dvd_q;
    quot_d = quot_q;
    part_d = part_q;
    if (start_i) begin
      step_d = SW'(CNT_W);
      dvd_d  = dividend_i;
      quot_d = '0;
      part_d = '0;
    end else if (step_q != '0) begin
      part_d = ge ? diff[swpc_pkg::DIV_W-1:0] : trial[swpc_pkg::DIV_W-1:0];
      dvd_d  = {dvd_q[CNT_W-2:0], 1'b0};
      quot_d = {quot_q[CNT_W-2:0], ge};
      step_d = step_q - SW'(1);
      done_d = (step_q == SW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    quot_q <= quot_d;
    part_q <= part_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = part_q;

endmodule

/* hdl/sliding_window_peak_counter_core.sv */
// ----------------------------------------------------------------------------
// sliding_window_peak_counter_core
// Sliding-log event rate counter with peak tracking and unit estimate.
// ----------------------------------------------------------------------------
// Timestamps are held in a chain of FIFO_DEPTH cells whose front is cell 0.
// Each accepted event is taken in the idle state; its expired entries are then
// removed from the front one at a time, and the event is then stored and its
// result registered once the output register is free. After a write to the
// divisor register, the next event that does not start a set first passes
// through the serial divider that rescales the unit count. A new event is
// taken while the previous result waits.
module sliding_window_peak_counter_core #(
  parameter int unsigned FIFO_DEPTH = swpc_pkg::FIFO_DEPTH_DEF,
  parameter int unsigned TIME_WIDTH = swpc_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [swpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [swpc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [swpc_pkg::TS_W-1:0]       timestamp_i,
  input  logic                            start_of_set_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [swpc_pkg::OUT_W-1:0]      window_count_o,
  output logic [swpc_pkg::OUT_W-1:0]      peak_count_o,
  output logic [swpc_pkg::OUT_W-1:0]      units_needed_o,
  output logic                            overflow_o
);

  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned CMP_W = (TIME_WIDTH > swpc_pkg::WIN_W) ? TIME_WIDTH
                                                                 : swpc_pkg::WIN_W;

  swpc_pkg::swpc_state_e      state_q, state_d;
  swpc_pkg::swpc_ctrl_t       ctrl;

  logic [swpc_pkg::WIN_W-1:0] win_q;
  logic [swpc_pkg::DIV_W-1:0] div_q;
  logic [swpc_pkg::DIV_W-1:0] div_wr;
  logic                       dirty_q, dirty_d;

  logic [TIME_WIDTH-1:0]      now_q, now_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [CNT_W-1:0]           peak_q, peak_d;
  logic [CNT_W-1:0]           units_q, units_d;
  logic [swpc_pkg::DIV_W-1:0] rem_q, rem_d;

  logic                       out_valid_q, out_valid_d;
  logic [swpc_pkg::OUT_W-1:0] wc_q, wc_d;
  logic [swpc_pkg::OUT_W-1:0] pk_q, pk_d;
  logic [swpc_pkg::OUT_W-1:0] un_q, un_d;
  logic                       ovf_q, ovf_d;

  logic                       in_acc;
  logic                       out_free;
  logic                       div_start;
  logic                       div_done;
  logic [CNT_W-1:0]           div_quot;
  logic [swpc_pkg::DIV_W-1:0] div_rem;

  logic [TIME_WIDTH-1:0]      cell_time [FIFO_DEPTH];
  logic [TIME_WIDTH-1:0]      front;
  logic [TIME_WIDTH-1:0]      age;
  logic                       expire;

  // timestamp chain
  for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
    logic [TIME_WIDTH-1:0] next_time;
    if (i == FIFO_DEPTH - 1) begin : g_last
      assign next_time = cell_time[i];
    end else begin : g_mid
      assign next_time = cell_time[i+1];
    end
    swpc_cell #(
      .TIME_WIDTH (TIME_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .fill_i      (cnt_q),
      .new_time_i  (now_q),
      .next_time_i (next_time),
      .time_o      (cell_time[i])
    );
  end

  swpc_div #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (peak_q),
    .divisor_i  (div_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign front  = cell_time[0];
  assign age    = now_q - front;
  assign expire = (front <= now_q) && (CMP_W'(age) >= CMP_W'(win_q));

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == swpc_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign div_wr      = cfg_data_i[swpc_pkg::DIV_W-1:0];

  always_comb begin
    logic                   full;
    logic [CNT_W-1:0]       cnt_new;
    logic [CNT_W-1:0]       peak_new;
    logic [CNT_W-1:0]       units_new;
    logic [swpc_pkg::DIV_W-1:0] rem_new;

    state_d     = state_q;
    ctrl        = '0;
    div_start   = 1'b0;
    dirty_d     = dirty_q;
    now_d       = now_q;
    cnt_d       = cnt_q;
    peak_d      = peak_q;
    units_d     = units_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !out_ready_i;
    wc_d        = wc_q;
    pk_d        = pk_q;
    un_d        = un_q;
    ovf_d       = ovf_q;
    full        = (cnt_q == CNT_W'(FIFO_DEPTH));
    cnt_new     = full ? cnt_q : cnt_q + CNT_W'(1);
    peak_new    = peak_q;
    units_new   = units_q;
    rem_new     = rem_q;
    if (cnt_new > peak_q) begin
      peak_new = cnt_new;
      if (rem_q == '0) begin
        units_new = units_q + CNT_W'(1);
        rem_new   = div_q - swpc_pkg::DIV_W'(1);
      end else begin
        rem_new = rem_q - swpc_pkg::DIV_W'(1);
      end
    end

    case (state_q)
      swpc_pkg::ST_IDLE: begin
        if (in_acc) begin
          now_d = TIME_WIDTH'(timestamp_i);
          if (start_of_set_i) begin
            cnt_d   = '0;
            peak_d  = '0;
            units_d = '0;
            rem_d   = '0;
            dirty_d = 1'b0;
            state_d = swpc_pkg::ST_SCAN;
          end else if (dirty_q) begin
            div_start = 1'b1;
            state_d   = swpc_pkg::ST_DIV;
          end else begin
            state_d = swpc_pkg::ST_SCAN;
          end
        end
      end
      swpc_pkg::ST_DIV: begin
        if (div_done) begin
          units_d = div_quot + CNT_W'(div_rem != '0);
          rem_d   = (div_rem == '0) ? '0 : div_q - div_rem;
          dirty_d = 1'b0;
          state_d = swpc_pkg::ST_SCAN;
        end
      end
      swpc_pkg::ST_SCAN: begin
        if ((cnt_q != '0) && expire) begin
          ctrl.pop = 1'b1;
          cnt_d    = cnt_q - CNT_W'(1);
        end else if (out_free) begin
          ctrl.push   = !full;
          cnt_d       = cnt_new;
          peak_d      = peak_new;
          units_d     = units_new;
          rem_d       = rem_new;
          wc_d        = swpc_pkg::OUT_W'(cnt_new);
          pk_d        = swpc_pkg::OUT_W'(peak_new);
          un_d        = swpc_pkg::OUT_W'(units_new);
          ovf_d       = full;
          out_valid_d = 1'b1;
          state_d     = swpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swpc_pkg::ST_IDLE;
      end
    endcase

    if (cfg_valid_i && (cfg_index_i == swpc_pkg::REG_DIVISOR)) begin
      dirty_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swpc_pkg::ST_IDLE;
      win_q       <= swpc_pkg::WIN_RESET;
      div_q       <= swpc_pkg::DIV_RESET;
      dirty_q     <= 1'b0;
      cnt_q       <= '0;
      peak_q      <= '0;
      units_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dirty_q     <= dirty_d;
      cnt_q       <= cnt_d;
      peak_q      <= peak_d;
      units_q     <= units_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && (cfg_index_i == swpc_pkg::REG_WINDOW)) begin
        win_q <= cfg_data_i[swpc_pkg::WIN_W-1:0];
      end
      if (cfg_valid_i && (cfg_index_i == swpc_pkg::REG_DIVISOR)) begin
        div_q <= (div_wr == '0) ? swpc_pkg::DIV_W'(1) : div_wr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    wc_q  <= wc_d;
    pk_q  <= pk_d;
    un_q  <= un_d;
    ovf_q <= ovf_d;
  end

  assign out_valid_o    = out_valid_q;
  assign window_count_o = wc_q;
  assign peak_count_o   = pk_q;
  assign units_needed_o = un_q;
  assign overflow_o     = ovf_q;

endmodule
